@@ design/ucc_pkg.sv @@
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared widths, constants and control/status types of the union closure
// counter.
// ----------------------------------------------------------------------------
package ucc_pkg;

  // Universe width: number of elements a set can hold
  localparam int UNIVERSE_BITS = 16;

  // Fixed port widths
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 17;

  // Internal widths follow the universe
  localparam int SET_W = UNIVERSE_BITS;
  localparam int CNT_W = UNIVERSE_BITS + 1;

  typedef logic [SET_W-1:0] set_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Number of distinct subsets of the universe
  localparam cnt_t CAPACITY = {1'b1, {SET_W{1'b0}}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic init_wr;      // clearing pass: write one entry of both stores
    logic load;         // take the request, rewind the walk
    logic append;       // test the looked-up union and append it if new
    logic idx_inc;      // advance the walk pointer
    logic idx_one;      // point the walk at the first non-empty set
    logic clr_wr;       // clear the visited bit of the set just read
    logic emit;         // capture the result
    logic total_reset;  // store back to holding the empty set only
  } ucc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic init_end;     // clearing pass at the last entry
    logic item_end;     // walk at the last set stored before the request
    logic clr_end;      // walk at the last stored set
    logic single;       // only the empty set is stored
    logic last;         // request closes the problem
  } ucc_stat_t;

endpackage

@@ design/union_closure_counter.sv @@
// ----------------------------------------------------------------------------
// union_closure_counter
// Running count of distinct unions of subsets of a stream of bit masks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its mask is OR-ed
// with every set stored before it; each new union is marked and appended.
// One result follows each request: out_valid is high for one cycle with the
// count of distinct sets (empty set included). The receiver cannot stall, so
// sample the result in that cycle. A request walks the sets stored before it:
// each stored set costs one list read, one bitmap read and one update. After
// a request flagged last, busy stays high while the stored sets other than
// the empty set are unmarked. After reset, busy stays high while the bitmap
// and the list are cleared, leaving only the empty set marked.
// ----------------------------------------------------------------------------
module union_closure_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ucc_pkg::MASK_W-1:0]  in_nbhd_mask,
  input  logic                        in_last_mask,
  output logic                        out_valid,
  output logic [ucc_pkg::COUNT_W-1:0] out_distinct_count,
  output logic                        out_final_flag
);

  ucc_pkg::ucc_cmd_t  cmd;
  ucc_pkg::ucc_stat_t stat;

  // Sequencer
  ucc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Stores and counters
  ucc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_nbhd_mask       (in_nbhd_mask),
    .in_last_mask       (in_last_mask),
    .out_distinct_count (out_distinct_count),
    .out_final_flag     (out_final_flag)
  );

endmodule

@@ design/ucc_dp.sv @@
// ----------------------------------------------------------------------------
// ucc_dp
// Datapath: visited bitmap, set list, walk pointer, set count and the
// result registers.
// ----------------------------------------------------------------------------
module ucc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ucc_pkg::ucc_cmd_t          cmd,
  output ucc_pkg::ucc_stat_t         stat,
  input  logic [ucc_pkg::MASK_W-1:0] in_nbhd_mask,
  input  logic                       in_last_mask,
  output logic [ucc_pkg::COUNT_W-1:0] out_distinct_count,
  output logic                       out_final_flag
);

  // Stores
  logic          seen_mem [ucc_pkg::CAPACITY];
  ucc_pkg::set_t list_mem [ucc_pkg::CAPACITY];

  // Control registers
  ucc_pkg::set_t idx_r, idx_nxt;
  ucc_pkg::cnt_t total_r, total_nxt;

  // Payload registers
  ucc_pkg::set_t mask_r;
  logic          last_r;
  ucc_pkg::cnt_t before_r;
  ucc_pkg::set_t list_rd_r;
  logic          seen_rd_r;
  ucc_pkg::set_t u_r;
  logic [ucc_pkg::COUNT_W-1:0] count_r;
  logic          final_r;

  // Write port selection
  logic          seen_we, seen_wdata;
  ucc_pkg::set_t seen_waddr;
  logic          list_we;
  ucc_pkg::set_t list_waddr, list_wdata;
  ucc_pkg::set_t u_nxt;
  logic          is_new;

  // Union of the set just read with the request mask
  assign u_nxt  = list_rd_r | mask_r;
  assign is_new = !seen_rd_r && (total_r < ucc_pkg::CAPACITY);

  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = idx_r;
    seen_wdata = 1'b0;
    list_we    = 1'b0;
    list_waddr = idx_r;
    list_wdata = '0;
    if (cmd.init_wr) begin
      seen_we    = 1'b1;
      seen_wdata = (idx_r == '0);
      list_we    = 1'b1;
    end else if (cmd.append && is_new) begin
      seen_we    = 1'b1;
      seen_waddr = u_r;
      seen_wdata = 1'b1;
      list_we    = 1'b1;
      list_waddr = total_r[ucc_pkg::SET_W-1:0];
      list_wdata = u_r;
    end else if (cmd.clr_wr) begin
      seen_we    = 1'b1;
      seen_waddr = list_rd_r;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    seen_rd_r <= seen_mem[u_nxt];
    u_r       <= u_nxt;
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rd_r <= list_mem[idx_r];
  end

  // Walk pointer and set count
  always_comb begin
    idx_nxt   = idx_r;
    total_nxt = total_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_one) begin
      idx_nxt = ucc_pkg::SET_W'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ucc_pkg::SET_W'(1);
    end
    if (cmd.total_reset) begin
      total_nxt = ucc_pkg::CNT_W'(1);
    end else if (cmd.append && is_new) begin
      total_nxt = total_r + ucc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      total_r <= ucc_pkg::CNT_W'(1);
    end else begin
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
    end
  end

  // Hold the request and the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r   <= ucc_pkg::SET_W'(in_nbhd_mask);
      last_r   <= in_last_mask;
      before_r <= total_r;
    end
    if (cmd.emit) begin
      count_r <= ucc_pkg::COUNT_W'(total_r);
      final_r <= last_r;
    end
  end

  assign out_distinct_count = count_r;
  assign out_final_flag     = final_r;

  // Status
  assign stat.init_end = &idx_r;
  assign stat.item_end = (ucc_pkg::CNT_W'(idx_r) + ucc_pkg::CNT_W'(1)) == before_r;
  assign stat.clr_end  = (ucc_pkg::CNT_W'(idx_r) + ucc_pkg::CNT_W'(1)) == total_r;
  assign stat.single   = total_r == ucc_pkg::CNT_W'(1);
  assign stat.last     = last_r;

endmodule

@@ design/ucc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ucc_ctrl
// Controller: sequences the clearing pass, the walk over stored sets for
// each request and the clearing walk after the last request of a problem.
// ----------------------------------------------------------------------------
module ucc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  ucc_pkg::ucc_stat_t stat,
  output ucc_pkg::ucc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD_LIST,
    S_RD_SEEN,
    S_UPDATE,
    S_DONE,
    S_CLR_RD,
    S_CLR_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.init_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_LIST;
        end
      end
      S_RD_LIST: begin
        state_nxt = S_RD_SEEN;
      end
      S_RD_SEEN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.append  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = stat.item_end ? S_DONE : S_RD_LIST;
      end
      S_DONE: begin
        cmd.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.single) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_one = 1'b1;
          state_nxt   = S_CLR_RD;
        end
      end
      S_CLR_RD: begin
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.clr_end) begin
          cmd.total_reset = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_CLR_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

@@ design/ucc_checker.sv @@
// ----------------------------------------------------------------------------
// ucc_checker
// Port-level checks of the union closure counter, bound to the top level.
// ----------------------------------------------------------------------------
module ucc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ucc_pkg::COUNT_W-1:0] out_distinct_count,
  input logic                        out_final_flag
);

  // Reset starts the clearing pass with no result pending
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("block not busy or strobing after reset");

  // A taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("request taken but block not busy");

  // The result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The empty set is always counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distinct_count != '0)
    else $error("zero count reported");

  // A non-final result leaves the block ready for the next request
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_flag |-> !busy)
    else $error("block busy after a non-final result");

endmodule

bind union_closure_counter ucc_checker u_ucc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_distinct_count (out_distinct_count),
  .out_final_flag     (out_final_flag)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the union closure counter. A directed opening hits
// the empty and full masks, repeats and a sixteen-singleton problem that
// reaches the largest count. It is followed by random problems of a few masks
// each, mixing dense, sparse, repeated and subset masks, with random idle
// gaps. Each request updates an in-bench closure tracker, and every result
// strobe is checked against the oldest expected count.
// ----------------------------------------------------------------------------
module tb;
  import ucc_pkg::*;

  localparam int          RANDOM_REQUESTS = 80;
  localparam int          END_DRAIN       = 1000;
  localparam longint      TIMEOUT_NS      = 25_000_000;

  typedef struct {
    logic [COUNT_W-1:0] distinct_count;
    logic               final_flag;
  } union_result_t;

  // Tracks the stored unions of the open problem and the counts still owed
  class closure_tracker;
    bit            seen_union[];
    set_t          union_list[$];
    union_result_t owed_results[$];
    int unsigned   error_count;
    int unsigned   checked_count;
    int unsigned   largest_count;

    function new();
      seen_union = new[1 << SET_W];
      union_list.push_back('0);
      seen_union[0] = 1'b1;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
    endtask

    // OR the mask into every set stored before it, append new unions
    function void note_request(input logic [MASK_W-1:0] mask, input logic last);
      set_t          universe_mask;
      set_t          merged;
      int unsigned   stored;
      union_result_t owed;
      universe_mask = set_t'(mask);
      stored = union_list.size();
      for (int unsigned i = 0; i < stored; i++) begin
        merged = union_list[i] | universe_mask;
        if (!seen_union[merged] && union_list.size() < CAPACITY) begin
          seen_union[merged] = 1'b1;
          union_list.push_back(merged);
        end
      end
      owed.distinct_count = COUNT_W'(union_list.size());
      owed.final_flag     = last;
      owed_results.push_back(owed);
      if (union_list.size() > largest_count) largest_count = union_list.size();
      // Close the problem: unmark stored sets, keep the empty set only
      if (last) begin
        foreach (union_list[i]) seen_union[union_list[i]] = 1'b0;
        union_list.delete();
        union_list.push_back('0);
        seen_union[0] = 1'b1;
      end
    endfunction

    task check_result(input logic [COUNT_W-1:0] count, input logic flag);
      union_result_t owed;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result count=%0d final=%0b", count, flag));
        return;
      end
      owed = owed_results.pop_front();
      checked_count++;
      if (count !== owed.distinct_count)
        report($sformatf("distinct_count got %0d, want %0d",
                         count, owed.distinct_count));
      if (flag !== owed.final_flag)
        report($sformatf("final_flag got %0b, want %0b", flag, owed.final_flag));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [MASK_W-1:0]  in_nbhd_mask = '0;
  logic               in_last_mask = 1'b0;
  logic               out_valid;
  logic [COUNT_W-1:0] out_distinct_count;
  logic               out_final_flag;

  closure_tracker     tracker;
  int unsigned        sent_count;
  int unsigned        problem_count;

  union_closure_counter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_nbhd_mask       (in_nbhd_mask),
    .in_last_mask       (in_last_mask),
    .out_valid          (out_valid),
    .out_distinct_count (out_distinct_count),
    .out_final_flag     (out_final_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_distinct_count, out_final_flag);
  end

  // Present a request and hold it until the block takes it
  task automatic send_request(input logic [MASK_W-1:0] mask, input logic last);
    @(negedge clk);
    start        <= 1'b1;
    in_nbhd_mask <= mask;
    in_last_mask <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(mask, last);
    sent_count++;
    if (last) problem_count++;
  endtask

  // Drop start and scramble the payload for a number of cycles
  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      start        <= 1'b0;
      in_nbhd_mask <= MASK_W'($urandom);
      in_last_mask <= 1'($urandom_range(0, 1));
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // Dense, sparse, repeated, subset, empty or full masks
  function automatic logic [MASK_W-1:0] pick_mask(input logic [MASK_W-1:0] prev);
    logic [MASK_W-1:0] mask;
    int unsigned       kind;
    kind = $urandom_range(0, 9);
    mask = '0;
    case (kind)
      0: mask = '0;
      1, 2, 3: mask = MASK_W'($urandom);
      4, 5, 6: begin
        repeat ($urandom_range(1, 3)) mask[$urandom_range(0, MASK_W - 1)] = 1'b1;
      end
      7: mask = prev;
      8: mask = prev & MASK_W'($urandom);
      default: mask = '1;
    endcase
    return mask;
  endfunction

  initial begin
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] prev;
    int unsigned       plen;
    bit                quiet;
    bit                paused;

    tracker = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty mask, full mask, a repeat, then close on an empty mask
    send_request('0, 1'b0);
    send_request('1, 1'b0);
    idle_sender(2);
    send_request('1, 1'b0);
    send_request('0, 1'b1);
    // Every single bit once: the closure fills the whole universe
    for (int b = 0; b < MASK_W; b++) begin
      mask    = '0;
      mask[b] = 1'b1;
      send_request(mask, b == MASK_W - 1);
      if (b % 5 == 4) idle_sender($urandom_range(1, 4));
    end
    // A problem of one full mask
    send_request('1, 1'b1);
    idle_sender(1);
    wait_drained();

    // Random problems of a few masks each
    paused = 1'b0;
    prev   = '0;
    while (sent_count < RANDOM_REQUESTS + 21) begin
      plen  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 6);
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < plen; k++) begin
        mask = pick_mask(prev);
        prev = mask;
        send_request(mask, k == plen - 1);
        if (!quiet) idle_sender(pick_gap());
      end
      // Hold off once until everything owed has come back
      if (!paused && sent_count > 70) begin
        idle_sender(1);
        wait_drained();
        paused = 1'b1;
      end
    end

    idle_sender(1);
    wait_drained();
    repeat (END_DRAIN) @(posedge clk);
    $display("Ran %0d requests over %0d closed problems; %0d counts checked.",
             sent_count, problem_count, tracker.checked_count);
    $display("Largest union count reached: %0d.", tracker.largest_count);
    if (tracker.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
